[hdl/frm_pkg.sv]
// ============================================================================
// Fragmentation ratio monitor package
// Shared widths, codes, reset values and the structs that pass between the
// monitor's modules.
// ============================================================================
`timescale 1ns / 1ps

package frm_pkg;

    // Field widths.
    localparam int RATIO_W        = 17;
    localparam int TIME_W         = 32;
    localparam int TREND_W        = 24;
    localparam int TOTAL_W        = 32;
    localparam int ALARM_W        = 2;
    localparam int SAMPLE_COUNT_W = 6;

    // Configuration port.
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] CFG_WARN_LEVEL       = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CRITICAL_LEVEL   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTERVAL_SECONDS = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_MONITOR_ON       = 2'd3;

    localparam logic [RATIO_W-1:0] WARN_LEVEL_RESET     = 17'd19661;
    localparam logic [RATIO_W-1:0] CRITICAL_LEVEL_RESET = 17'd32768;
    localparam logic [TIME_W-1:0]  INTERVAL_RESET       = 32'd60;
    localparam logic               MONITOR_ON_RESET     = 1'b1;

    // Request commands.
    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Alarm codes.
    localparam logic [ALARM_W-1:0] ALARM_NONE     = 2'd0;
    localparam logic [ALARM_W-1:0] ALARM_WARNING  = 2'd1;
    localparam logic [ALARM_W-1:0] ALARM_CRITICAL = 2'd2;

    // Trend arithmetic. The scaled difference |delta| * 3600 stays below 2^28 only while |delta| is below 74566.
    localparam logic [TIME_W-1:0] TREND_MIN_SECONDS = 32'd36;
    localparam int                SECONDS_PER_HOUR  = 3600;
    localparam int                PRODUCT_W         = 28;

    typedef struct packed {
        logic [RATIO_W-1:0] warn_level;
        logic [RATIO_W-1:0] critical_level;
        logic [TIME_W-1:0]  interval_seconds;
        logic               monitor_on;
    } cfg_t;

    typedef struct packed {
        logic                       sampled;
        logic [ALARM_W-1:0]         alarm_level;
        logic [RATIO_W-1:0]         min_seen;
        logic [RATIO_W-1:0]         max_seen;
        logic [RATIO_W-1:0]         window_average;
        logic signed [TREND_W-1:0]  trend_hourly;
        logic [TOTAL_W-1:0]         warn_total;
        logic [TOTAL_W-1:0]         critical_total;
        logic [SAMPLE_COUNT_W-1:0]  sample_count;
        logic                       healthy;
    } result_t;

endpackage

[hdl/frm_divider.sv]
// ============================================================================
// Fragmentation ratio monitor divider
// Restoring unsigned divider that retires one quotient bit per cycle.
// ============================================================================
`timescale 1ns / 1ps

module frm_divider #(
    parameter int DIVIDEND_W = 28,
    parameter int DIVISOR_W  = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CNT_W = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVIDEND_W);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            // The remainder stays below the divisor, so it fits its width.
            rem_next = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[hdl/frm_core.sv]
// ============================================================================
// Fragmentation ratio monitor core
// History memory, running statistics and the sequencer that reads, updates
// and writes back one request at a time.
// ============================================================================
`timescale 1ns / 1ps

module frm_core #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  frm_pkg::cfg_t                cfg,
    input  logic                         in_valid,
    output logic                         busy,
    input  logic                         command,
    input  logic [frm_pkg::TIME_W-1:0]   now_seconds,
    input  logic [frm_pkg::RATIO_W-1:0]  sample_ratio,
    output logic                         res_valid,
    input  logic                         res_take,
    output frm_pkg::result_t             result
);

    localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int CNT_W   = $clog2(HISTORY_DEPTH + 1);
    localparam int SUM_W   = frm_pkg::RATIO_W + $clog2(HISTORY_DEPTH);
    localparam int ENTRY_W = frm_pkg::TIME_W + frm_pkg::RATIO_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD_OLD,
        S_RD_OLDEST,
        S_MUL,
        S_TSTART,
        S_WAIT,
        S_DONE
    } state_t;

    state_t state_reg, state_next;

    logic [frm_pkg::TIME_W-1:0]          now_reg, now_next;
    logic [frm_pkg::RATIO_W-1:0]         ratio_reg, ratio_next;
    logic [IDX_W-1:0]                    slot_reg, slot_next;
    logic [CNT_W-1:0]                    held_reg, held_next;
    logic [SUM_W-1:0]                    sum_reg, sum_next;
    logic [frm_pkg::RATIO_W-1:0]         low_reg, low_next;
    logic [frm_pkg::RATIO_W-1:0]         high_reg, high_next;
    logic [frm_pkg::RATIO_W-1:0]         mean_reg, mean_next;
    logic signed [frm_pkg::TREND_W-1:0]  trend_reg, trend_next;
    logic [frm_pkg::TOTAL_W-1:0]         warn_cnt_reg, warn_cnt_next;
    logic [frm_pkg::TOTAL_W-1:0]         crit_cnt_reg, crit_cnt_next;
    logic [frm_pkg::TIME_W-1:0]          last_reg, last_next;
    logic                                checked_reg, checked_next;
    logic [frm_pkg::RATIO_W-1:0]         newest_reg, newest_next;
    logic                                sampled_reg, sampled_next;
    logic [frm_pkg::ALARM_W-1:0]         level_reg, level_next;
    logic [frm_pkg::RATIO_W-1:0]         dmag_reg, dmag_next;
    logic                                neg_reg, neg_next;
    logic [frm_pkg::TIME_W-1:0]          dt_reg, dt_next;
    logic                                tgo_reg, tgo_next;
    logic [frm_pkg::PRODUCT_W-1:0]       prod_reg, prod_next;

    // History memory: time in the upper bits, ratio in the lower bits.
    logic [ENTRY_W-1:0] mem [HISTORY_DEPTH];
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    // Dividers.
    logic                           mean_start, mean_busy;
    logic [SUM_W-1:0]               mean_quo;
    logic                           trend_start, trend_busy;
    logic [frm_pkg::PRODUCT_W-1:0]  trend_quo;

    // Helper terms.
    logic                           full;
    logic [CNT_W-1:0]               held_new;
    logic [IDX_W-1:0]               slot_inc;
    logic [frm_pkg::RATIO_W-1:0]    old_ratio;
    logic [frm_pkg::TIME_W-1:0]     oldest_time;
    logic [frm_pkg::TIME_W-1:0]     elapsed;
    logic                           due;
    logic [frm_pkg::TREND_W-1:0]    trend_mag;

    assign full      = (held_reg == CNT_W'(HISTORY_DEPTH));
    assign held_new  = full ? held_reg : held_reg + CNT_W'(1);
    assign slot_inc  = (slot_reg == IDX_W'(HISTORY_DEPTH - 1)) ? '0 : slot_reg + IDX_W'(1);
    assign old_ratio = rd_data_reg[frm_pkg::RATIO_W-1:0];
    assign oldest_time = rd_data_reg[ENTRY_W-1:frm_pkg::RATIO_W];
    assign elapsed   = now_reg - oldest_time;
    assign due       = !checked_reg || (now_seconds < last_reg) ||
                       ((now_seconds - last_reg) >= cfg.interval_seconds);
    assign trend_mag = frm_pkg::TREND_W'(trend_quo);

    always_comb
    begin
        state_next    = state_reg;
        now_next      = now_reg;
        ratio_next    = ratio_reg;
        slot_next     = slot_reg;
        held_next     = held_reg;
        sum_next      = sum_reg;
        low_next      = low_reg;
        high_next     = high_reg;
        mean_next     = mean_reg;
        trend_next    = trend_reg;
        warn_cnt_next = warn_cnt_reg;
        crit_cnt_next = crit_cnt_reg;
        last_next     = last_reg;
        checked_next  = checked_reg;
        newest_next   = newest_reg;
        sampled_next  = sampled_reg;
        level_next    = level_reg;
        dmag_next     = dmag_reg;
        neg_next      = neg_reg;
        dt_next       = dt_reg;
        tgo_next      = tgo_reg;
        prod_next     = prod_reg;
        rd_en         = 1'b0;
        rd_addr       = slot_reg;
        wr_en         = 1'b0;
        wr_addr       = slot_reg;
        wr_data       = {now_reg, ratio_reg};
        mean_start    = 1'b0;
        trend_start   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    now_next     = now_seconds;
                    ratio_next   = sample_ratio;
                    sampled_next = 1'b0;
                    level_next   = frm_pkg::ALARM_NONE;
                    state_next   = S_DONE;
                    if (command == frm_pkg::CMD_CLEAR)
                    begin
                        slot_next     = '0;
                        held_next     = '0;
                        sum_next      = '0;
                        low_next      = '0;
                        high_next     = '0;
                        mean_next     = '0;
                        trend_next    = '0;
                        warn_cnt_next = '0;
                        crit_cnt_next = '0;
                    end
                    else if (cfg.monitor_on && due)
                    begin
                        // Fetch the entry about to be overwritten.
                        rd_en        = 1'b1;
                        rd_addr      = slot_reg;
                        sampled_next = 1'b1;
                        state_next   = S_RD_OLD;
                    end
                end
            end

            S_RD_OLD:
            begin
                sum_next = (full ? sum_reg - SUM_W'(old_ratio) : sum_reg) + SUM_W'(ratio_reg);
                wr_en     = 1'b1;
                wr_addr   = slot_reg;
                slot_next = slot_inc;
                held_next = held_new;
                if ((held_reg == '0) || (ratio_reg < low_reg))
                begin
                    low_next = ratio_reg;
                end
                if ((held_reg == '0) || (ratio_reg > high_reg))
                begin
                    high_next = ratio_reg;
                end
                if (ratio_reg >= cfg.critical_level)
                begin
                    level_next = frm_pkg::ALARM_CRITICAL;
                    if (crit_cnt_reg != {frm_pkg::TOTAL_W{1'b1}})
                    begin
                        crit_cnt_next = crit_cnt_reg + frm_pkg::TOTAL_W'(1);
                    end
                end
                else if (ratio_reg >= cfg.warn_level)
                begin
                    level_next = frm_pkg::ALARM_WARNING;
                    if (warn_cnt_reg != {frm_pkg::TOTAL_W{1'b1}})
                    begin
                        warn_cnt_next = warn_cnt_reg + frm_pkg::TOTAL_W'(1);
                    end
                end
                last_next    = now_reg;
                checked_next = 1'b1;
                newest_next  = ratio_reg;
                // The oldest entry sits at slot zero until the ring wraps,
                // and right after the write slot once it has.
                rd_en   = 1'b1;
                rd_addr = (held_new == CNT_W'(HISTORY_DEPTH)) ? slot_inc : '0;
                state_next = S_RD_OLDEST;
            end

            S_RD_OLDEST:
            begin
                mean_start = 1'b1;
                tgo_next   = 1'b0;
                if (held_reg >= CNT_W'(2))
                begin
                    if (now_reg < oldest_time)
                    begin
                        trend_next = '0;
                    end
                    else if (elapsed > frm_pkg::TREND_MIN_SECONDS)
                    begin
                        tgo_next  = 1'b1;
                        dt_next   = elapsed;
                        neg_next  = (ratio_reg < old_ratio);
                        dmag_next = (ratio_reg < old_ratio) ? old_ratio - ratio_reg
                                                            : ratio_reg - old_ratio;
                    end
                end
                state_next = S_MUL;
            end

            S_MUL:
            begin
                prod_next = frm_pkg::PRODUCT_W'(dmag_reg) *
                            frm_pkg::PRODUCT_W'(frm_pkg::SECONDS_PER_HOUR);
                state_next = S_TSTART;
            end

            S_TSTART:
            begin
                trend_start = tgo_reg;
                state_next  = S_WAIT;
            end

            S_WAIT:
            begin
                if (!mean_busy && !trend_busy)
                begin
                    mean_next = frm_pkg::RATIO_W'(mean_quo);
                    if (tgo_reg)
                    begin
                        // Elapsed time above 36 s keeps the quotient within
                        // the trend limit, so no clamp is needed.
                        trend_next = neg_reg ? -$signed(trend_mag) : $signed(trend_mag);
                    end
                    state_next = S_DONE;
                end
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            slot_reg     <= '0;
            held_reg     <= '0;
            sum_reg      <= '0;
            low_reg      <= '0;
            high_reg     <= '0;
            mean_reg     <= '0;
            trend_reg    <= '0;
            warn_cnt_reg <= '0;
            crit_cnt_reg <= '0;
            last_reg     <= '0;
            checked_reg  <= 1'b0;
            newest_reg   <= '0;
            sampled_reg  <= 1'b0;
            level_reg    <= frm_pkg::ALARM_NONE;
            tgo_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            slot_reg     <= slot_next;
            held_reg     <= held_next;
            sum_reg      <= sum_next;
            low_reg      <= low_next;
            high_reg     <= high_next;
            mean_reg     <= mean_next;
            trend_reg    <= trend_next;
            warn_cnt_reg <= warn_cnt_next;
            crit_cnt_reg <= crit_cnt_next;
            last_reg     <= last_next;
            checked_reg  <= checked_next;
            newest_reg   <= newest_next;
            sampled_reg  <= sampled_next;
            level_reg    <= level_next;
            tgo_reg      <= tgo_next;
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg   <= now_next;
        ratio_reg <= ratio_next;
        dmag_reg  <= dmag_next;
        neg_reg   <= neg_next;
        dt_reg    <= dt_next;
        prod_reg  <= prod_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    frm_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_mean_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mean_start),
        .dividend (sum_reg),
        .divisor  (held_reg),
        .busy     (mean_busy),
        .quotient (mean_quo)
    );

    frm_divider #(
        .DIVIDEND_W (frm_pkg::PRODUCT_W),
        .DIVISOR_W  (frm_pkg::TIME_W)
    ) u_trend_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (trend_start),
        .dividend (prod_reg),
        .divisor  (dt_reg),
        .busy     (trend_busy),
        .quotient (trend_quo)
    );

    assign busy      = (state_reg != S_IDLE);
    assign res_valid = (state_reg == S_DONE);

    always_comb
    begin
        result.sampled        = sampled_reg;
        result.alarm_level    = level_reg;
        result.min_seen       = low_reg;
        result.max_seen       = high_reg;
        result.window_average = mean_reg;
        result.trend_hourly   = trend_reg;
        result.warn_total     = warn_cnt_reg;
        result.critical_total = crit_cnt_reg;
        result.sample_count   = frm_pkg::SAMPLE_COUNT_W'(held_reg);
        result.healthy        = (held_reg == '0) || (newest_reg < cfg.warn_level);
    end

endmodule

[hdl/fragmentation_ratio_monitor_unit.sv]
// ============================================================================
// Fragmentation ratio monitor
// Records timestamped fragmentation-ratio samples into a ring history and
// reports extremes, windowed average, hourly trend and alarm counts.
// ============================================================================
// Requests arrive on in_valid/in_stall with command, now_seconds and
// sample_ratio and are taken at an edge with in_valid high and in_stall low.
// Every request yields one result on out_valid/out_stall. A clear or a skipped
// check (monitor off or too early) goes straight to the done state and
// is then loaded into the output register. A recorded check needs two memory
// reads, a write-back, a multiply stage and a bit-serial divide for the
// average; when the trend is updated, a second bit-serial divide for the
// trend starts after the average divide, and the result waits for both.
// in_stall stays high while a request is in work, until its result is loaded
// into the output register. A finished result waits in an
// output register; when the receiver stalls with it full, the core holds its
// result and in_stall stays high. Configuration writes (cfg_write, cfg_index,
// cfg_data) take effect at once and belong only in idle periods. Reset
// restores the default registers, clears all statistics and forgets the last
// check time; the history memory is not cleared.
// ============================================================================
`timescale 1ns / 1ps

module fragmentation_ratio_monitor_unit #(
    parameter int HISTORY_DEPTH = 32
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_write,
    input  logic [frm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [frm_pkg::CFG_DATA_W-1:0]      cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [frm_pkg::TIME_W-1:0]          now_seconds,
    input  logic [frm_pkg::RATIO_W-1:0]         sample_ratio,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                sampled,
    output logic [frm_pkg::ALARM_W-1:0]         alarm_level,
    output logic [frm_pkg::RATIO_W-1:0]         min_seen,
    output logic [frm_pkg::RATIO_W-1:0]         max_seen,
    output logic [frm_pkg::RATIO_W-1:0]         window_average,
    output logic signed [frm_pkg::TREND_W-1:0]  trend_hourly,
    output logic [frm_pkg::TOTAL_W-1:0]         warn_total,
    output logic [frm_pkg::TOTAL_W-1:0]         critical_total,
    output logic [frm_pkg::SAMPLE_COUNT_W-1:0]  sample_count,
    output logic                                healthy
);

    frm_pkg::cfg_t    cfg_reg, cfg_next;
    frm_pkg::result_t res_reg, res_next;
    frm_pkg::result_t core_result;
    logic             out_valid_reg, out_valid_next;
    logic             core_busy;
    logic             core_valid;
    logic             load;

    // Configuration registers.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (cfg_index)
                frm_pkg::CFG_WARN_LEVEL:
                begin
                    cfg_next.warn_level = cfg_data[frm_pkg::RATIO_W-1:0];
                end
                frm_pkg::CFG_CRITICAL_LEVEL:
                begin
                    cfg_next.critical_level = cfg_data[frm_pkg::RATIO_W-1:0];
                end
                frm_pkg::CFG_INTERVAL_SECONDS:
                begin
                    cfg_next.interval_seconds = cfg_data[frm_pkg::TIME_W-1:0];
                end
                frm_pkg::CFG_MONITOR_ON:
                begin
                    cfg_next.monitor_on = cfg_data[0];
                end
                default:
                begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.warn_level       <= frm_pkg::WARN_LEVEL_RESET;
            cfg_reg.critical_level   <= frm_pkg::CRITICAL_LEVEL_RESET;
            cfg_reg.interval_seconds <= frm_pkg::INTERVAL_RESET;
            cfg_reg.monitor_on       <= frm_pkg::MONITOR_ON_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    frm_core #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .in_valid     (in_valid),
        .busy         (core_busy),
        .command      (command),
        .now_seconds  (now_seconds),
        .sample_ratio (sample_ratio),
        .res_valid    (core_valid),
        .res_take     (load),
        .result       (core_result)
    );

    // Output register: loads when empty or when its content leaves this cycle.
    assign load = core_valid && (!out_valid_reg || !out_stall);

    always_comb
    begin
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        if (load)
        begin
            res_next       = core_result;
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign in_stall       = core_busy;
    assign out_valid      = out_valid_reg;
    assign sampled        = res_reg.sampled;
    assign alarm_level    = res_reg.alarm_level;
    assign min_seen       = res_reg.min_seen;
    assign max_seen       = res_reg.max_seen;
    assign window_average = res_reg.window_average;
    assign trend_hourly   = res_reg.trend_hourly;
    assign warn_total     = res_reg.warn_total;
    assign critical_total = res_reg.critical_total;
    assign sample_count   = res_reg.sample_count;
    assign healthy        = res_reg.healthy;

endmodule
